>>> hdl/gjls_pkg.sv
package gjls_pkg;

	localparam int N_UNKNOWNS = 4;
	localparam int NCOLS = N_UNKNOWNS + 1;
	localparam int NCOEF = N_UNKNOWNS * NCOLS;
	localparam int AW = $clog2(NCOEF);
	localparam int RW = $clog2(N_UNKNOWNS);
	localparam int CW = $clog2(NCOLS);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		q_t             value;
		logic           last;
	} coef_item_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FETCH_PV,
		ST_FETCH_TG,
		ST_DIV,
		ST_ROW_RD,
		ST_ROW_MUL,
		ST_ROW_WR,
		ST_ZERO,
		ST_ROOT_RD,
		ST_ROOT_GO,
		ST_ROOT_DIV,
		ST_EMIT
	} be_state_t;

	function automatic q_t sat_mag(input logic [63:0] m, input logic neg);
		logic [32:0] c;
		c = (m > 64'h1_0000_0000) ? 33'h1_0000_0000 : m[32:0];
		if (neg) begin
			sat_mag = (c >= 33'h0_8000_0000) ? 32'sh8000_0000 : q_t'(-$signed({1'b0, c[31:0]}));
		end else begin
			sat_mag = (c >= 33'h0_8000_0000) ? 32'sh7FFF_FFFF : q_t'(c[31:0]);
		end
	endfunction

	function automatic logic [31:0] mag(input q_t x);
		mag = x[31] ? 32'(-x) : 32'(x);
	endfunction

endpackage

>>> hdl/gjls_front.sv
module gjls_front
	import gjls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  q_t         coef_value,
	output logic       q_valid,
	input  logic       q_ready,
	output coef_item_t q_item
);

	coef_item_t          mem_q [QDEPTH];
	logic [QAW:0]        wr_q;
	logic [QAW:0]        rd_q;
	logic [AW:0]         cnt_q;
	logic                push;
	logic                pop;

	assign in_ready = (wr_q - rd_q) != (QAW + 1)'(QDEPTH);
	assign q_valid  = wr_q != rd_q;
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_q[QAW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[QAW-1:0]] <= '{value: coef_value, last: cnt_q == (AW + 1)'(NCOEF - 1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q  <= wr_q + 1'b1;
				cnt_q <= (cnt_q == (AW + 1)'(NCOEF - 1)) ? '0 : cnt_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/gjls_divider.sv
module gjls_divider
	import gjls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q_t   num,
	input  q_t   den,
	output logic done,
	output q_t   quot
);

	logic [48:0] rem_q;
	logic [48:0] nb_q;
	logic [31:0] d_q;
	logic [48:0] qv_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [49:0] trial;
	logic [48:0] numr;

	assign numr  = {1'b0, mag(num), 16'h0} + 49'(mag(den) >> 1);
	assign trial = {rem_q, nb_q[48]} - {18'h0, d_q};
	assign quot  = sat_mag(64'(qv_q), neg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nb_q  <= numr;
			d_q   <= mag(den);
			qv_q  <= '0;
			neg_q <= num[31] != den[31];
		end else if (busy_q) begin
			nb_q <= {nb_q[47:0], 1'b0};
			if (!trial[49]) begin
				rem_q <= trial[48:0];
				qv_q  <= {qv_q[47:0], 1'b1};
			end else begin
				rem_q <= {rem_q[47:0], nb_q[48]};
				qv_q  <= {qv_q[47:0], 1'b0};
			end
		end
	end

endmodule

>>> hdl/gjls_back.sv
module gjls_back
	import gjls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  coef_item_t q_item,
	output logic       out_valid,
	input  logic       out_ready,
	output q_t         root_value,
	output logic [3:0] root_index,
	output logic       is_last,
	output logic       singular
);

	q_t              mem [NCOEF];
	be_state_t       st_q, st_d;
	logic [AW-1:0]   wa_q;
	logic            phase_q;
	logic [RW-1:0]   tgt_q, piv_q;
	logic [CW-1:0]   k_q;
	logic            zp_q;
	q_t              pv_q, tv_q, f_q, rd_q;
	logic [63:0]     prod_q;
	logic            pneg_q;
	logic            div_start, div_done;
	q_t              div_num, div_den, div_quot;
	logic [AW-1:0]   ra;
	logic [AW-1:0]   pa;
	logic            ov_q;
	logic            we;
	logic [AW-1:0]   waddr;
	q_t              wdata;
	logic            step_fwd_last, step_bwd_last;
	logic signed [32:0] diff;

	function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		addr = AW'(r * NCOLS + c);
	endfunction

	gjls_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign step_fwd_last = tgt_q == RW'(N_UNKNOWNS - 1);
	assign step_bwd_last = tgt_q == '0;
	assign diff = 33'(rd_q) - 33'(sat_mag(prod_q, pneg_q));
	assign out_valid = ov_q;
	assign pa = (st_q == ST_ROOT_RD) ? addr(tgt_q, CW'(tgt_q)) : addr(piv_q, CW'(piv_q));

	always_comb begin
		ra = addr(piv_q, CW'(piv_q));
		case (st_q)
			ST_FETCH_PV: ra = addr(tgt_q, CW'(piv_q));
			ST_FETCH_TG: ra = addr(tgt_q, CW'(piv_q));
			ST_ROW_RD:   ra = addr(piv_q, k_q);
			ST_ROW_MUL:  ra = addr(tgt_q, k_q);
			ST_ROOT_RD:  ra = addr(tgt_q, CW'(N_UNKNOWNS));
			default:     ra = addr(piv_q, CW'(piv_q));
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ra];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:     if (q_valid && q_item.last) st_d = ST_FETCH_PV;
			ST_FETCH_PV: st_d = ST_FETCH_TG;
			ST_FETCH_TG: st_d = (pv_q == '0 || rd_q == '0) ? ST_ZERO : ST_DIV;
			ST_DIV:      if (div_done) st_d = ST_ROW_RD;
			ST_ROW_RD:   st_d = ST_ROW_MUL;
			ST_ROW_MUL:  st_d = ST_ROW_WR;
			ST_ROW_WR:   st_d = (k_q == CW'(NCOLS - 1)) ? ST_ZERO : ST_ROW_RD;
			ST_ZERO: begin
				if (!phase_q && step_fwd_last && piv_q == RW'(N_UNKNOWNS - 2)) begin
					st_d = ST_FETCH_PV;
				end else if (phase_q && step_bwd_last && piv_q == RW'(1)) begin
					st_d = ST_ROOT_RD;
				end else begin
					st_d = ST_FETCH_PV;
				end
			end
			ST_ROOT_RD:  st_d = ST_ROOT_GO;
			ST_ROOT_GO:  st_d = ST_ROOT_DIV;
			ST_ROOT_DIV: if (div_done || pv_q == '0) st_d = ST_EMIT;
			ST_EMIT: begin
				if (!ov_q || out_ready) begin
					st_d = (tgt_q == RW'(N_UNKNOWNS - 1)) ? ST_LOAD : ST_ROOT_RD;
				end
			end
			default:     st_d = ST_LOAD;
		endcase
	end

	always_comb begin
		q_ready   = st_q == ST_LOAD;
		we        = 1'b0;
		waddr     = wa_q;
		wdata     = q_item.value;
		div_start = 1'b0;
		div_num   = tv_q;
		div_den   = pv_q;
		case (st_q)
			ST_LOAD: we = q_valid;
			ST_FETCH_TG: begin
				div_num   = rd_q;
				div_start = pv_q != '0 && rd_q != '0;
			end
			ST_ROW_WR: begin
				we    = 1'b1;
				waddr = addr(tgt_q, k_q);
				wdata = (diff > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
					(diff < -33'sh0_8000_0000) ? 32'sh8000_0000 : q_t'(diff);
			end
			ST_ZERO: begin
				we    = pv_q != '0;
				waddr = addr(tgt_q, CW'(piv_q));
				wdata = '0;
			end
			ST_ROOT_RD: begin
				div_start = 1'b0;
			end
			ST_ROOT_GO: begin
				div_num   = rd_q;
				div_start = pv_q != '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			wa_q    <= '0;
			phase_q <= 1'b0;
			piv_q   <= '0;
			tgt_q   <= RW'(1);
			k_q     <= '0;
			zp_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_LOAD: begin
					if (q_valid) begin
						wa_q <= q_item.last ? '0 : wa_q + 1'b1;
					end
				end
				ST_FETCH_PV: zp_q <= zp_q;
				ST_FETCH_TG: begin
					k_q <= '0;
					if (pv_q == '0) zp_q <= 1'b1;
				end
				ST_ROW_WR: k_q <= k_q + 1'b1;
				ST_ZERO: begin
					if (!phase_q) begin
						if (step_fwd_last) begin
							if (piv_q == RW'(N_UNKNOWNS - 2)) begin
								phase_q <= 1'b1;
								piv_q   <= RW'(N_UNKNOWNS - 1);
								tgt_q   <= RW'(N_UNKNOWNS - 2);
							end else begin
								piv_q <= piv_q + 1'b1;
								tgt_q <= piv_q + RW'(2);
							end
						end else begin
							tgt_q <= tgt_q + 1'b1;
						end
					end else begin
						if (step_bwd_last) begin
							if (piv_q == RW'(1)) begin
								tgt_q <= '0;
							end else begin
								piv_q <= piv_q - 1'b1;
								tgt_q <= piv_q - RW'(2);
							end
						end else begin
							tgt_q <= tgt_q - 1'b1;
						end
					end
				end
				ST_ROOT_DIV: begin
					if (pv_q == '0) zp_q <= 1'b1;
				end
				ST_EMIT: begin
					if (!ov_q || out_ready) begin
						ov_q       <= 1'b1;
						if (tgt_q == RW'(N_UNKNOWNS - 1)) begin
							tgt_q   <= RW'(1);
							piv_q   <= '0;
							phase_q <= 1'b0;
							zp_q    <= 1'b0;
						end else begin
							tgt_q <= tgt_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: pivot, numerator, factor, product and root word.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_FETCH_TG: begin
				pv_q <= pv_q;
			end
			ST_ROW_MUL: begin
				prod_q <= (64'(mag(f_q)) * 64'(mag(rd_q)) + 64'h8000) >> 16;
				pneg_q <= f_q[31] != rd_q[31];
			end
			ST_EMIT: begin
				if (!ov_q || out_ready) begin
					root_value <= (zp_q || pv_q == '0) ? '0 : div_quot;
					root_index <= 4'(tgt_q);
					is_last    <= tgt_q == RW'(N_UNKNOWNS - 1);
					singular   <= zp_q || pv_q == '0;
				end
			end
			default: ;
		endcase
		if (st_q == ST_FETCH_PV || st_q == ST_ROOT_RD) begin
			pv_q <= mem[pa];
		end
		if (st_q == ST_FETCH_TG) begin
			tv_q <= rd_q;
		end
		if (st_q == ST_DIV && div_done) begin
			f_q <= div_quot;
		end
	end

endmodule

>>> hdl/gauss_jordan_linear_solver.sv
// Gauss-Jordan solver for an N by N+1 augmented system in signed Q16.16.
// Input channel: in_valid/in_ready with coef_value, one coefficient per
// transfer, row-major. A small queue decouples loading from solving.
// Output channel: out_valid/out_ready with root_value, root_index, is_last
// and singular; N roots per matrix, in index order, last one marked.
// Elimination runs with no pivoting. Each row operation gets its factor
// from the shared radix-2 divider, then reads, multiplies and writes back
// each column; an operation is skipped for a zero pivot or zero target.
// Each root is one more quotient from the same divider. The next matrix
// is loaded only after the last root of the current solve has entered
// the output register.
// A zero pivot skips that row operation and sets singular with zero roots.
// Up to four coefficients of the next matrix wait in the queue while a
// solve runs; after that in_ready stays low until the solve ends.
// A stalled receiver holds the current root; the solver waits on it.
// Reset clears all control state; matrix contents need no clearing.
module gauss_jordan_linear_solver
	import gjls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  q_t         coef_value,
	output logic       out_valid,
	input  logic       out_ready,
	output q_t         root_value,
	output logic [3:0] root_index,
	output logic       is_last,
	output logic       singular
);

	logic       q_valid, q_ready;
	coef_item_t q_item;

	gjls_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coef_value (coef_value),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	gjls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root_value (root_value),
		.root_index (root_index),
		.is_last    (is_last),
		.singular   (singular)
	);

`ifndef ASSERT_OFF
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> root_index == 4'(N_UNKNOWNS - 1))
		else $error("last root has wrong index");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> root_value == '0)
		else $error("singular root not zero");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_index))
		else $error("stalled root changed");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench
	import gjls_pkg::*;
();

	typedef struct {
		q_t         value;
		logic [3:0] index;
		logic       last;
		logic       sing;
	} root_t;

	class root_scoreboard;
		q_t    mat[NCOEF];
		int    loaded;
		bit    zp;
		root_t pending[$];
		int    mismatches;
		int    roots_checked;
		int    solves;
		int    singular_solves;

		function automatic q_t sat64(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return q_t'(v);
		endfunction

		function automatic longint unsigned mg(q_t x);
			longint sx;
			sx = x;
			return sx < 0 ? longint'(-sx) : longint'(sx);
		endfunction

		function automatic q_t signed_sat(longint unsigned m, bit neg);
			longint v;
			if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
			v = neg ? -longint'(m) : longint'(m);
			return sat64(v);
		endfunction

		function automatic q_t qdiv(q_t a, q_t b);
			longint unsigned num, den;
			num = mg(a) << 16;
			den = mg(b);
			return signed_sat((num + den / 2) / den, (a < 0) != (b < 0));
		endfunction

		function automatic q_t qmul(q_t a, q_t b);
			longint unsigned p;
			p = (mg(a) * mg(b) + 64'h8000) >> 16;
			return signed_sat(p, (a < 0) != (b < 0));
		endfunction

		function automatic void eliminate(int tgt, int piv);
			q_t pv, f, d;
			pv = mat[piv * NCOLS + piv];
			if (pv == 0) begin
				zp = 1;
				return;
			end
			f = qdiv(mat[tgt * NCOLS + piv], pv);
			for (int k = 0; k < NCOLS; k++) begin
				d = qmul(f, mat[piv * NCOLS + k]);
				mat[tgt * NCOLS + k] = sat64(longint'(mat[tgt * NCOLS + k]) - longint'(d));
			end
			mat[tgt * NCOLS + piv] = 0;
		endfunction

		function void note_coef(q_t c);
			q_t roots[N_UNKNOWNS];
			root_t r;
			q_t dg;
			mat[loaded] = c;
			loaded++;
			if (loaded < NCOEF) return;
			for (int j = 0; j < N_UNKNOWNS - 1; j++)
				for (int i = j + 1; i < N_UNKNOWNS; i++)
					eliminate(i, j);
			for (int j = N_UNKNOWNS - 1; j > 0; j--)
				for (int i = j - 1; i >= 0; i--)
					eliminate(i, j);
			for (int i = 0; i < N_UNKNOWNS; i++) begin
				dg = mat[i * NCOLS + i];
				if (dg == 0) begin
					zp = 1;
					roots[i] = 0;
				end else begin
					roots[i] = qdiv(mat[i * NCOLS + N_UNKNOWNS], dg);
				end
			end
			for (int i = 0; i < N_UNKNOWNS; i++) begin
				r.value = zp ? 32'sd0 : roots[i];
				r.index = 4'(i);
				r.last = (i == N_UNKNOWNS - 1);
				r.sing = zp;
				pending.insert(pending.size(), r);
			end
			solves++;
			if (zp) singular_solves++;
			loaded = 0;
			zp = 0;
		endfunction

		function void check_root(q_t v, logic [3:0] idx, logic lst, logic sg);
			root_t e;
			roots_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected root transfer: value %h index %0d", v, idx);
				return;
			end
			e = pending.pop_front();
			if (v !== e.value || idx !== e.index || lst !== e.last || sg !== e.sing) begin
				mismatches++;
				if (mismatches <= 10)
					$display("root mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
						e.value, e.index, e.last, e.sing, v, idx, lst, sg);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	q_t         coef_value;
	logic       out_valid;
	logic       out_ready;
	q_t         root_value;
	logic [3:0] root_index;
	logic       is_last;
	logic       singular;

	root_scoreboard sb;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;
	int  cycle_count;
	localparam int CYCLE_LIMIT = 200000;

	gauss_jordan_linear_solver u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .coef_value(coef_value),
		.out_valid(out_valid), .out_ready(out_ready), .root_value(root_value),
		.root_index(root_index), .is_last(is_last), .singular(singular)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("gauss_jordan_linear_solver regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_root(root_value, root_index, is_last, singular);
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_coef(q_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		coef_value <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_coef(c);
	endtask

	function automatic q_t rand_coef(int kind);
		case (kind)
			0: return q_t'($urandom);
			1: return q_t'(int'($urandom_range(8 * 65536)) - 4 * 65536);
			default: return q_t'(int'($urandom_range(64)) - 32) <<< 16;
		endcase
	endfunction

	task automatic send_matrix(int kind);
		q_t c;
		for (int r = 0; r < N_UNKNOWNS; r++)
			for (int k = 0; k < NCOLS; k++) begin
				c = rand_coef(kind);
				// Keep the diagonal strong in well-formed systems.
				if (kind != 0 && r == k)
					c = q_t'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(40, 100)) * 65536);
				send_coef(c);
			end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		coef_value = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity system, then extreme values and saturation.
		for (int i = 0; i < NCOEF; i++)
			send_coef((i % NCOLS == i / NCOLS) ? 32'sh0001_0000 : (i % NCOLS == N_UNKNOWNS ?
				q_t'(i) <<< 16 : 32'sd0));
		for (int i = 0; i < NCOEF; i++)
			send_coef(i % NCOLS == i / NCOLS ? 32'sd1 :
				(i % 2 ? 32'sh7FFF_FFFF : 32'sh8000_0000));
		// Zero leading pivot: singular.
		for (int i = 0; i < NCOEF; i++)
			send_coef(i == 0 ? 32'sd0 : rand_coef(1));
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 61 : 19) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 61 : 19) : 0;
			for (int m = 0; m < 2; m++)
				send_matrix((m + phase) % 3);
			drain();
		end

		// Long receiver hold-off so the input side fills and stalls.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_matrix(1);
				send_matrix(2);
				send_matrix(1);
				in_valid <= 1'b0;
			end
		join
		drain();

		$display("covered %0d solves (%0d singular), %0d roots checked",
			sb.solves, sb.singular_solves, sb.roots_checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("gauss_jordan_linear_solver regression: pass");
		else
			$display("gauss_jordan_linear_solver regression: fail");
		$finish;
	end

endmodule
